// ===== design/tsr_pkg.sv =====
`timescale 1ns / 1ps

package tsr_pkg;

    // input word modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // strategy register codes
    localparam logic [1:0] STRAT_LINEAR  = 2'd0;
    localparam logic [1:0] STRAT_NEAREST = 2'd1;
    localparam logic [1:0] STRAT_LATEST  = 2'd2;
    localparam logic [1:0] STRAT_EXACT   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // multiplier operand slice width for the interpolation step
    localparam int unsigned MUL_SLICE = 16;

endpackage

// ===== design/time_series_resampler_unit.sv =====
`timescale 1ns / 1ps

// Time series resampler. Load a sorted series of (timestamp, value) points with
// append words, then send target queries in ascending time order; each input
// word returns exactly one result word. Points live in two memories of
// STORE_DEPTH entries (times and values) with one write port and a registered
// read.
// The block handles one word at a time and holds o_in_stall high while it works.
// Clear, append and rejected queries go straight to the result. A query first
// walks the pointer forward past the points at or before its time, each step a
// memory read then a compare, and in linear mode then runs the bit-serial
// fraction divide and the sliced 64x16 multiply.
// A finished result waits in the output register, so the next word is taken
// while the previous result is stalled.
// The strategy register is written through the cfg channel, always ready; write
// it only while the block is idle.
module time_series_resampler_unit
    import tsr_pkg::*;
#(
    parameter int unsigned STORE_DEPTH   = 1024,
    parameter int unsigned FRACTION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_strategy,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [63:0] i_timestamp,
    input  logic [63:0] i_sample_value,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_value,
    output logic        o_no_match,
    output logic [1:0]  o_status
);

    localparam int unsigned AW   = $clog2(STORE_DEPTH);
    localparam int unsigned CNTW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned NCH  = (FRACTION_BITS + MUL_SLICE - 1) / MUL_SLICE;
    localparam int unsigned QW   = NCH * MUL_SLICE;
    localparam int unsigned ACCW = 64 + QW;
    localparam int unsigned PPW  = 64 + MUL_SLICE;
    localparam int unsigned DCW  = $clog2(FRACTION_BITS + 1);
    localparam int unsigned KW   = $clog2(NCH + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_RD0  = 12'b0000_0000_0010,
        S_CAP0 = 12'b0000_0000_0100,
        S_WRD  = 12'b0000_0000_1000,
        S_WCMP = 12'b0000_0001_0000,
        S_RDP  = 12'b0000_0010_0000,
        S_CAPP = 12'b0000_0100_0000,
        S_CAPQ = 12'b0000_1000_0000,
        S_DIV  = 12'b0001_0000_0000,
        S_MUL  = 12'b0010_0000_0000,
        S_ACC  = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

    // point store
    logic [63:0] mem_time  [STORE_DEPTH];
    logic [63:0] mem_value [STORE_DEPTH];
    logic [63:0] r_rd_time;
    logic [63:0] r_rd_value;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    t_state r_state;
    logic [1:0]      r_strategy;
    logic [CNTW-1:0] r_count;
    logic [AW-1:0]   r_walk;
    logic [63:0]     r_prev;
    logic            r_seen;

    // working registers for one query
    logic [63:0]     r_ts;
    logic [AW-1:0]   r_p;
    logic [63:0]     r_t0, r_v0, r_t1, r_v1;
    logic [63:0]     r_rem, r_den, r_mag;
    logic            r_neg;
    logic [QW-1:0]   r_q;
    logic [DCW-1:0]  r_dcnt;
    logic [KW-1:0]   r_k;
    logic [PPW-1:0]  r_pp;
    logic [ACCW-1:0] r_acc;
    logic            r_lin;

    // pending result
    logic [63:0] r_res;
    logic        r_nm;
    logic [1:0]  r_st;

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic        r_out_nm;
    logic [1:0]  r_out_st;

    logic            in_acc;
    logic [CNTW-1:0] last;
    logic [AW-1:0]   walk_clamp;
    logic            p_below_last;
    logic [64:0]     div_sh;
    logic            div_take;
    logic [63:0]     step_mag;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign wr_en       = in_acc && (i_mode == MODE_APPEND) && (r_count != CNTW'(STORE_DEPTH));

    assign last         = r_count - CNTW'(1);
    assign walk_clamp   = ({1'b0, r_walk} > (AW + 1)'(last)) ? last[AW-1:0] : r_walk;
    assign p_below_last = (CNTW'(r_p) < last);

    // one restoring-divide step; the shifted-out bit forces a subtract
    assign div_sh   = {r_rem, 1'b0};
    assign div_take = div_sh[64] || (div_sh[63:0] >= r_den);
    assign step_mag = r_acc[FRACTION_BITS +: 64];

    always_comb begin
        unique case (r_state)
            S_RD0:   rd_addr = '0;
            S_RDP:   rd_addr = r_p;
            S_WRD,
            S_CAPP:  rd_addr = r_p + AW'(1);
            default: rd_addr = r_p;
        endcase
    end

    // store: write on append, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_time[r_count[AW-1:0]]  <= i_timestamp;
            mem_value[r_count[AW-1:0]] <= i_sample_value;
        end
        r_rd_time  <= mem_time[rd_addr];
        r_rd_value <= mem_value[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strategy <= STRAT_LINEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_strategy <= i_cfg_strategy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_walk      <= '0;
            r_prev      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop a taken result word unless a new one loads this cycle
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ts    <= i_timestamp;
                        r_res   <= '0;
                        r_nm    <= 1'b0;
                        r_st    <= ST_OK;
                        r_state <= S_FIN;
                        priority if (i_mode == MODE_CLEAR) begin
                            r_count <= '0;
                            r_walk  <= '0;
                            r_prev  <= '0;
                            r_seen  <= 1'b0;
                        end else if (i_mode == MODE_APPEND) begin
                            if (r_count == CNTW'(STORE_DEPTH)) begin
                                r_st <= ST_FULL;
                            end else begin
                                r_count <= r_count + CNTW'(1);
                            end
                        end else if (i_mode == MODE_QUERY) begin
                            priority if (r_seen && ($signed(i_timestamp) < $signed(r_prev))) begin
                                r_st <= ST_ORDER;
                            end else if (r_count == '0) begin
                                r_st <= ST_EMPTY;
                            end else begin
                                r_prev  <= i_timestamp;
                                r_seen  <= 1'b1;
                                r_p     <= walk_clamp;
                                r_state <= S_RD0;
                            end
                        end else begin
                            r_st <= ST_OK;
                        end
                    end
                end
                S_RD0: r_state <= S_CAP0;
                S_CAP0: begin
                    r_t0    <= r_rd_time;
                    r_v0    <= r_rd_value;
                    r_state <= S_WRD;
                end
                S_WRD: r_state <= p_below_last ? S_WCMP : S_RDP;
                S_WCMP: begin
                    if ($signed(r_rd_time) <= $signed(r_ts)) begin
                        r_p     <= r_p + AW'(1);
                        r_state <= S_WRD;
                    end else begin
                        r_state <= S_RDP;
                    end
                end
                S_RDP: r_state <= S_CAPP;
                S_CAPP: begin
                    r_t1    <= r_rd_time;
                    r_v1    <= r_rd_value;
                    r_state <= S_CAPQ;
                end
                S_CAPQ: begin
                    r_walk  <= r_p;
                    r_state <= S_FIN;
                    priority if (r_strategy == STRAT_EXACT) begin
                        if (r_t1 == r_ts) r_res <= r_v1;
                        else              r_nm  <= 1'b1;
                    end else if ($signed(r_ts) <= $signed(r_t0)) begin
                        r_res <= r_v0;
                    end else if (!p_below_last) begin
                        r_res <= r_v1;
                    end else if (r_strategy == STRAT_NEAREST) begin
                        r_res <= ((r_ts - r_t1) < (r_rd_time - r_ts)) ? r_v1 : r_rd_value;
                    end else if (r_strategy == STRAT_LATEST) begin
                        r_res <= r_v1;
                    end else begin
                        r_rem   <= r_ts - r_t1;
                        r_den   <= r_rd_time - r_t1;
                        r_neg   <= $signed(r_rd_value) < $signed(r_v1);
                        r_mag   <= ($signed(r_rd_value) < $signed(r_v1)) ?
                                   (r_v1 - r_rd_value) : (r_rd_value - r_v1);
                        r_q     <= '0;
                        r_dcnt  <= DCW'(FRACTION_BITS);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_take ? (div_sh[63:0] - r_den) : div_sh[63:0];
                    r_q    <= {r_q[QW-2:0], div_take};
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        r_acc   <= '0;
                        r_k     <= KW'(NCH);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // slice the fraction from the top, one 64x16 product a pass
                    r_pp    <= PPW'(r_mag) * PPW'(r_q[QW-1 -: MUL_SLICE]);
                    r_q     <= r_q << MUL_SLICE;
                    r_k     <= r_k - KW'(1);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= (r_acc << MUL_SLICE) + ACCW'(r_pp);
                    r_state <= (r_k == '0) ? S_FIN : S_MUL;
                end
                S_FIN: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_nm    <= r_nm;
                        r_out_st    <= r_st;
                        r_state     <= S_IDLE;
                        // linear mode lands here with the product still to apply
                        if (r_lin) begin
                            r_out_value <= r_neg ? (r_v1 - step_mag) : (r_v1 + step_mag);
                        end else begin
                            r_out_value <= r_res;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // marks a query that went through the interpolation path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_lin <= 1'b0;
        end else if (r_state == S_DIV) begin
            r_lin <= 1'b1;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_no_match     = r_out_nm;
    assign o_status       = r_out_st;

endmodule

// ===== design/tsr_checker.sv =====
`timescale 1ns / 1ps

module tsr_checker
    import tsr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_result_value,
    input logic        o_no_match,
    input logic [1:0]  o_status
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value))
        else $error("result word changed while stalled");

    // one word in flight: stall right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted back to back");

    // no match carries a zero value and ok status
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_match |-> o_result_value == '0 && o_status == ST_OK)
        else $error("no-match result with value or status");

    // error status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_result_value == '0 && !o_no_match)
        else $error("error result with nonzero payload");

    // drop output valid on reset
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind time_series_resampler_unit tsr_checker u_tsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value),
    .o_no_match     (o_no_match),
    .o_status       (o_status)
);
